@@ hdl/escape_sequence_transcoder_defines.svh @@
// Assertion helpers used by the checker of the transcoder.
`ifndef ESCAPE_SEQUENCE_TRANSCODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_TRANSCODER_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define EST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held.
`define EST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/est_pkg.sv @@
`default_nettype none
package est_pkg;

  localparam int UNIT_W   = 32;
  localparam int ERR_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 2;
  localparam int TDATA_W  = 40;
  localparam int PAD_W    = TDATA_W - UNIT_W - ERR_W;
  localparam int CP_W     = 21;
  localparam int GROUP_N  = 4;
  localparam int CNT_W    = 3;

  // Unit width codes; codes two and three both give 32-bit units
  localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_16 = 2'd1;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UTF8   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_ESCAPE = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ESC      = 3'd1,
    PH_HEXFIRST = 3'd2,
    PH_HEX      = 3'd3,
    PH_HEXOVF   = 3'd4,
    PH_OCT      = 3'd5,
    PH_UTF8     = 3'd6
  } phase_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [ERR_W-1:0]  err;
  } result_t;

  // Results raised by one input transaction, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    result_t [GROUP_N-1:0]     res;
  } group_t;

endpackage
`default_nettype wire

@@ hdl/est_decode.sv @@
`default_nettype none
module est_decode (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [est_pkg::MODE_W-1:0]  mode,
  input  wire logic                        fire,
  input  wire logic                        action,
  input  wire logic [est_pkg::BYTE_W-1:0]  byte_in,
  output est_pkg::group_t                  grp
);
  import est_pkg::*;

  localparam logic [31:0] HEX_LIMIT = 32'hFFFF_FFFF / 16;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    logic [CNT_W-1:0]              count;
    logic [GROUP_N-1:0][UNIT_W-1:0] units;
  } enc_t;

  // Decode one hex digit; bit 4 flags a valid digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [UNIT_W-1:0] trunc_unit(input logic [31:0] v,
                                                  input logic [MODE_W-1:0] m);
    logic [UNIT_W-1:0] u;
    unique case (m)
      MODE_8:  u = {24'd0, v[7:0]};
      MODE_16: u = {16'd0, v[15:0]};
      default: u = v;
    endcase
    return u;
  endfunction

  function automatic enc_t encode_char(input logic [CP_W-1:0] cp, input logic numeric,
                                       input logic [MODE_W-1:0] m);
    enc_t e;
    logic [CP_W-1:0] v;
    e = '0;
    e.count = 3'd1;
    v = cp - 21'h10000;
    if (numeric) begin
      e.units[0] = trunc_unit({11'd0, cp}, m);
    end else if (m == MODE_8) begin
      if (cp < 21'h80) begin
        e.units[0] = {11'd0, cp};
      end else if (cp < 21'h800) begin
        e.count    = 3'd2;
        e.units[0] = {24'd0, 3'b110, cp[10:6]};
        e.units[1] = {24'd0, 2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
        e.count    = 3'd3;
        e.units[0] = {24'd0, 4'b1110, cp[15:12]};
        e.units[1] = {24'd0, 2'b10, cp[11:6]};
        e.units[2] = {24'd0, 2'b10, cp[5:0]};
      end else begin
        e.count    = 3'd4;
        e.units[0] = {24'd0, 5'b11110, cp[20:18]};
        e.units[1] = {24'd0, 2'b10, cp[17:12]};
        e.units[2] = {24'd0, 2'b10, cp[11:6]};
        e.units[3] = {24'd0, 2'b10, cp[5:0]};
      end
    end else if (m == MODE_16 && cp >= 21'h10000) begin
      e.count    = 3'd2;
      e.units[0] = {16'd0, 6'b110110, v[19:10]};
      e.units[1] = {16'd0, 6'b110111, v[9:0]};
    end else begin
      e.units[0] = {11'd0, cp};
    end
    return e;
  endfunction

  phase_t            phase_r, phase_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [1:0]        dcnt_r, dcnt_nxt;
  logic [1:0]        cont_r, cont_nxt;
  logic [2:0]        slen_r, slen_nxt;

  logic              pre_v, pre_num;
  logic [ERR_W-1:0]  pre_err;
  logic              ch_v, ch_num;
  logic [CP_W-1:0]   ch_cp;
  logic              er_v;
  logic [ERR_W-1:0]  er_code;
  logic              run_idle;
  logic [4:0]        hv;
  logic [31:0]       acc_oct;
  logic [CP_W-1:0]   acc_u;
  logic [CP_W-1:0]   minv;
  logic              bad_cp;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    cont_nxt  = cont_r;
    slen_nxt  = slen_r;
    pre_v     = 1'b0;
    pre_num   = 1'b0;
    pre_err   = ERR_OK;
    ch_v      = 1'b0;
    ch_num    = 1'b0;
    ch_cp     = '0;
    er_v      = 1'b0;
    er_code   = ERR_OK;
    run_idle  = 1'b0;
    hv        = hex_val(byte_in);
    acc_oct   = {acc_r[28:0], byte_in[2:0]};
    acc_u     = {acc_r[14:0], byte_in[5:0]};
    unique case (slen_r)
      3'd2:    minv = 21'h80;
      3'd3:    minv = 21'h800;
      default: minv = 21'h10000;
    endcase
    bad_cp = (acc_u < minv) || (acc_u >= 21'hD800 && acc_u <= 21'hDFFF) ||
             (acc_u > 21'h10FFFF);

    if (action == ACT_END) begin
      // Flush whatever construct is open, then append the terminator
      unique case (phase_r)
        PH_HEX, PH_OCT: begin
          pre_v   = 1'b1;
          pre_num = 1'b1;
        end
        PH_HEXOVF: begin
          pre_v   = 1'b1;
          pre_err = ERR_RANGE;
        end
        PH_ESC, PH_HEXFIRST: begin
          pre_v   = 1'b1;
          pre_err = ERR_ESCAPE;
        end
        PH_UTF8: begin
          pre_v   = 1'b1;
          pre_err = ERR_UTF8;
        end
        default: ;
      endcase
      phase_nxt = PH_IDLE;
      acc_nxt   = '0;
      dcnt_nxt  = '0;
      cont_nxt  = '0;
      slen_nxt  = '0;
      ch_v      = 1'b1;
    end else begin
      unique case (phase_r)
        PH_ESC: begin
          phase_nxt = PH_IDLE;
          acc_nxt   = '0;
          dcnt_nxt  = '0;
          cont_nxt  = '0;
          slen_nxt  = '0;
          unique case (byte_in)
            CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: begin
              ch_v  = 1'b1;
              ch_cp = {13'd0, byte_in};
            end
            CH_A: begin ch_v = 1'b1; ch_cp = 21'd7;  end
            CH_B: begin ch_v = 1'b1; ch_cp = 21'd8;  end
            CH_F: begin ch_v = 1'b1; ch_cp = 21'd12; end
            CH_N: begin ch_v = 1'b1; ch_cp = 21'd10; end
            CH_R: begin ch_v = 1'b1; ch_cp = 21'd13; end
            CH_T: begin ch_v = 1'b1; ch_cp = 21'd9;  end
            CH_V: begin ch_v = 1'b1; ch_cp = 21'd11; end
            CH_X: phase_nxt = PH_HEXFIRST;
            default: begin
              if (byte_in[7:3] == 5'b00110) begin
                acc_nxt   = {29'd0, byte_in[2:0]};
                dcnt_nxt  = 2'd1;
                phase_nxt = PH_OCT;
              end else begin
                er_v    = 1'b1;
                er_code = ERR_ESCAPE;
              end
            end
          endcase
        end
        PH_HEXFIRST, PH_HEX, PH_HEXOVF: begin
          if (hv[4]) begin
            // Absorb digits once overflowed
            if (phase_r == PH_HEXOVF) begin
              phase_nxt = PH_HEXOVF;
            end else if (phase_r == PH_HEX && acc_r > HEX_LIMIT) begin
              phase_nxt = PH_HEXOVF;
            end else begin
              acc_nxt   = {acc_r[27:0], hv[3:0]};
              phase_nxt = PH_HEX;
            end
          end else begin
            pre_v = 1'b1;
            unique case (phase_r)
              PH_HEXFIRST: pre_err = ERR_ESCAPE;
              PH_HEXOVF:   pre_err = ERR_RANGE;
              default:     pre_num = 1'b1;
            endcase
            run_idle = 1'b1;
          end
        end
        PH_OCT: begin
          if (byte_in[7:3] == 5'b00110) begin
            if (dcnt_r == 2'd2) begin
              ch_v      = 1'b1;
              ch_num    = 1'b1;
              ch_cp     = acc_oct[CP_W-1:0];
              phase_nxt = PH_IDLE;
              acc_nxt   = '0;
              dcnt_nxt  = '0;
            end else begin
              acc_nxt  = acc_oct;
              dcnt_nxt = dcnt_r + 2'd1;
            end
          end else begin
            pre_v    = 1'b1;
            pre_num  = 1'b1;
            run_idle = 1'b1;
          end
        end
        PH_UTF8: begin
          if (byte_in[7:6] != 2'b10) begin
            pre_v    = 1'b1;
            pre_err  = ERR_UTF8;
            run_idle = 1'b1;
          end else if (cont_r > 2'd1) begin
            acc_nxt  = {11'd0, acc_u};
            cont_nxt = cont_r - 2'd1;
          end else begin
            if (bad_cp) begin
              er_v    = 1'b1;
              er_code = ERR_UTF8;
            end else begin
              ch_v  = 1'b1;
              ch_cp = acc_u;
            end
            phase_nxt = PH_IDLE;
            acc_nxt   = '0;
            cont_nxt  = '0;
            slen_nxt  = '0;
          end
        end
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        // Plain byte outside any construct
        phase_nxt = PH_IDLE;
        acc_nxt   = '0;
        dcnt_nxt  = '0;
        cont_nxt  = '0;
        slen_nxt  = '0;
        if (byte_in == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else if (!byte_in[7]) begin
          ch_v  = 1'b1;
          ch_cp = {13'd0, byte_in};
        end else if (byte_in[7:5] == 3'b110) begin
          phase_nxt = PH_UTF8;
          acc_nxt   = {27'd0, byte_in[4:0]};
          slen_nxt  = 3'd2;
          cont_nxt  = 2'd1;
        end else if (byte_in[7:4] == 4'b1110) begin
          phase_nxt = PH_UTF8;
          acc_nxt   = {28'd0, byte_in[3:0]};
          slen_nxt  = 3'd3;
          cont_nxt  = 2'd2;
        end else if (byte_in[7:3] == 5'b11110) begin
          phase_nxt = PH_UTF8;
          acc_nxt   = {29'd0, byte_in[2:0]};
          slen_nxt  = 3'd4;
          cont_nxt  = 2'd3;
        end else begin
          er_v    = 1'b1;
          er_code = ERR_UTF8;
        end
      end
    end
  end

  enc_t    enc;
  group_t  main_grp;
  result_t pre_res;

  always_comb begin
    enc      = encode_char(ch_cp, ch_num, mode);
    main_grp = '0;
    if (er_v) begin
      main_grp.count       = 3'd1;
      main_grp.res[0].unit = '0;
      main_grp.res[0].err  = er_code;
    end else if (ch_v) begin
      main_grp.count = enc.count;
      for (int i = 0; i < GROUP_N; i++) begin
        main_grp.res[i].unit = enc.units[i];
        main_grp.res[i].err  = ERR_OK;
      end
    end
    pre_res.unit = pre_num ? trunc_unit(acc_r, mode) : '0;
    pre_res.err  = pre_err;
    // A prefix result goes first; what follows it is never more than one unit
    if (pre_v) begin
      grp.count  = main_grp.count + 3'd1;
      grp.res[0] = pre_res;
      for (int i = 1; i < GROUP_N; i++) begin
        grp.res[i] = main_grp.res[i-1];
      end
    end else begin
      grp = main_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      dcnt_r  <= '0;
      cont_r  <= '0;
      slen_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      cont_r  <= cont_nxt;
      slen_r  <= slen_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/est_serial.sv @@
`default_nettype none
module est_serial (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire est_pkg::group_t              grp,
  output logic                              space,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [est_pkg::TDATA_W-1:0]       out_tdata,
  output logic                              out_tlast
);
  import est_pkg::*;

  result_t [GROUP_N-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [1:0]            rd_r, rd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r, out_res_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_free;
  logic                  move;

  always_comb begin
    out_free      = !out_valid_r || out_tready;
    move          = out_free && (cnt_r != '0);
    space         = (cnt_r == '0) || (cnt_r == 3'd1 && out_free);
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    // Advance the head of the buffer into the output register
    if (move) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = buf_r[rd_r];
      out_last_nxt  = (cnt_r == 3'd1);
      cnt_nxt       = cnt_r - 3'd1;
      rd_nxt        = rd_r + 2'd1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      buf_nxt = grp.res;
      cnt_nxt = grp.count;
      rd_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r      <= buf_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_res_r.err, out_res_r.unit};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

@@ hdl/escape_sequence_transcoder.sv @@
// String literal transcoder: decodes C escapes and UTF-8 in a literal body
// and re-encodes each character as 8-, 16- or 32-bit code units.
// Input channel in_*: one source byte per transaction in in_tdata; in_tuser
//   set marks the end of the literal (byte ignored), which flushes any open
//   construct and appends a zero unit.
// Result channel out_*: one code unit per transaction; out_tlast marks the
//   final unit raised by one input transaction. Errors come as a zero unit
//   with a nonzero error code.
// Config channel cfg_*: unit width code, always ready; write it only while
//   no transaction is in flight.
// Throughput: one input byte per cycle while each byte yields at most one
//   unit and out_tready stays high; a byte that yields more units holds the
//   input until they drain, the result channel moving one unit per transaction.
// Path: units are registered in the result buffer, then in the output register.
// Reset: decoder back to idle, result buffer empty, 8-bit units selected.
// Receiver stall: the output register holds its unit, and input transactions
//   are still taken into the result buffer behind it while that buffer is empty.
`default_nettype none
module escape_sequence_transcoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [est_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] byte_in
  input  wire logic                          in_tuser,   // [0] action
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [est_pkg::TDATA_W-1:0]        out_tdata,  // [31:0] code_unit,
                                                         // [33:32] status, rest zero
  output logic                               out_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [est_pkg::MODE_W-1:0]    cfg_data    // [1:0] unit_size_mode
);
  import est_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              space;
  logic              in_fire;
  group_t            grp;

  // Register write is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_8;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // Take a byte whenever the result buffer can hold its units
  assign in_tready = space;
  assign in_fire   = in_tvalid && space;

  est_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode_r),
    .fire    (in_fire),
    .action  (in_tuser),
    .byte_in (in_tdata),
    .grp     (grp)
  );

  est_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .grp        (grp),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

@@ hdl/est_checker.sv @@
`default_nettype none
`include "escape_sequence_transcoder_defines.svh"
module est_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [est_pkg::BYTE_W-1:0]    in_tdata,
  input wire logic                          in_tuser,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [est_pkg::TDATA_W-1:0]   out_tdata,
  input wire logic                          out_tlast
);
  import est_pkg::*;

  // A stalled result holds
  `EST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")
  // Error results carry a zero code unit
  `EST_ASSERT_NOW(a_err_zero, clk, rst_n, out_tvalid && (out_tdata[UNIT_W +: ERR_W] != ERR_OK), out_tdata[UNIT_W-1:0] == '0, "error result with nonzero code unit")
  // Input is only held off while units wait to drain
  `EST_ASSERT_NEXT(a_stall_cause, clk, rst_n, !in_tready, out_tvalid, "input held off with no result pending")
  // A waiting input transaction holds
  `EST_ASSERT_NEXT(a_in_hold, clk, rst_n, in_tvalid && !in_tready, in_tvalid && $stable(in_tdata) && $stable(in_tuser), "input changed while stalled")

endmodule

bind escape_sequence_transcoder est_checker u_est_checker (.*);
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
module testbench;
  import est_pkg::*;

  // Unit width codes above sixteen bits; both select 32-bit units
  localparam logic [MODE_W-1:0] MODE_32     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_32_ALT = 2'd3;

  // Row kinds of the opening table: the result is typed in, or predicted
  localparam logic KNOWN     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam logic [7:0] BSL = 8'h5C;   // backslash

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 22;
  localparam int MAX_GAP       = 15;
  localparam int INTRO_N       = 29;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [ERR_W-1:0]  err;
    logic              last;
  } unit_rec_t;

  typedef struct packed {
    logic              act;
    logic [7:0]        data;
    logic              known;
    logic [UNIT_W-1:0] unit;
    logic [ERR_W-1:0]  err;
  } intro_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [BYTE_W-1:0]   in_tdata;    // [7:0] byte_in
  logic                in_tuser;    // [0] action
  logic                out_tvalid;
  logic                out_tready;
  logic [TDATA_W-1:0]  out_tdata;   // [31:0] code_unit, [33:32] status
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [MODE_W-1:0]   cfg_data;    // [1:0] unit_size_mode

  escape_sequence_transcoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Code units still owed by the block, oldest first
  unit_rec_t units_due [$];
  int        mismatches  = 0;
  int        items_taken = 0;
  int        cycle_count = 0;
  bit        in_calm     = 1'b0;
  bit        out_calm    = 1'b0;

  // Decoder copy: width code, phase and running state
  logic [MODE_W-1:0] unit_mode;
  phase_t            dec_phase;
  logic [31:0]       dec_acc;
  logic [1:0]        oct_digits;
  logic [1:0]        cont_left;
  logic [2:0]        seq_len;

  // Units raised by the transaction being decoded
  logic [UNIT_W-1:0] step_unit [GROUP_N];
  logic [ERR_W-1:0]  step_err  [GROUP_N];
  int                step_n;

  logic [7:0] simple_letters [11] = '{"'", "\"", "?", BSL, "a", "b", "f", "n", "r", "t", "v"};

  // Opening table, run with 8-bit units straight after reset
  intro_row_t intro_rows [INTRO_N] = '{
    '{ACT_BYTE, 8'h00, KNOWN,     32'h00, ERR_OK},     // lowest byte
    '{ACT_BYTE, 8'h7F, KNOWN,     32'h7F, ERR_OK},     // highest ASCII
    '{ACT_BYTE, 8'hFF, KNOWN,     32'h00, ERR_UTF8},   // never a lead byte
    '{ACT_BYTE, 8'h80, KNOWN,     32'h00, ERR_UTF8},   // stray continuation
    '{ACT_BYTE, 8'hC1, PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, 8'hBF, KNOWN,     32'h00, ERR_UTF8},   // overlong two-byte form
    '{ACT_BYTE, 8'hF4, PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "A",   PREDICTED, 32'h00, ERR_OK},     // sequence broken by ASCII
    '{ACT_BYTE, BSL,   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "q",   KNOWN,     32'h00, ERR_ESCAPE}, // unknown escape letter
    '{ACT_BYTE, BSL,   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "x",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "g",   PREDICTED, 32'h00, ERR_OK},     // hex escape without digits
    '{ACT_BYTE, BSL,   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "3",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "7",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "7",   KNOWN,     32'hFF, ERR_OK},     // third octal digit closes
    '{ACT_BYTE, BSL,   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "x",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},
    '{ACT_BYTE, "F",   PREDICTED, 32'h00, ERR_OK},     // ninth digit overflows
    '{ACT_END,  8'h00, PREDICTED, 32'h00, ERR_OK}      // end during overflow
  };

  logic [MODE_W-1:0] phase_modes [4] = '{MODE_16, MODE_32, MODE_32_ALT, MODE_8};

  // ---------------------------------------------------------------- decoder

  function automatic void dec_unit(input logic [31:0] u, input logic [ERR_W-1:0] e);
    if (step_n < GROUP_N) begin
      step_unit[step_n] = u;
      step_err[step_n]  = e;
      step_n++;
    end
  endfunction

  // Numeric escapes go out raw; characters are re-encoded for the unit width
  function automatic void dec_char(input logic [31:0] cp, input logic numeric);
    logic [31:0] v;
    if (numeric) begin
      if (unit_mode == MODE_8)       dec_unit(cp & 32'hFF, ERR_OK);
      else if (unit_mode == MODE_16) dec_unit(cp & 32'hFFFF, ERR_OK);
      else                           dec_unit(cp, ERR_OK);
    end else if (unit_mode == MODE_8) begin
      if (cp < 32'h80) begin
        dec_unit(cp, ERR_OK);
      end else if (cp < 32'h800) begin
        dec_unit(32'hC0 | (cp >> 6), ERR_OK);
        dec_unit(32'h80 | (cp & 32'h3F), ERR_OK);
      end else if (cp < 32'h10000) begin
        dec_unit(32'hE0 | (cp >> 12), ERR_OK);
        dec_unit(32'h80 | ((cp >> 6) & 32'h3F), ERR_OK);
        dec_unit(32'h80 | (cp & 32'h3F), ERR_OK);
      end else begin
        dec_unit(32'hF0 | ((cp >> 18) & 32'h07), ERR_OK);
        dec_unit(32'h80 | ((cp >> 12) & 32'h3F), ERR_OK);
        dec_unit(32'h80 | ((cp >> 6) & 32'h3F), ERR_OK);
        dec_unit(32'h80 | (cp & 32'h3F), ERR_OK);
      end
    end else if (unit_mode == MODE_16 && cp >= 32'h10000) begin
      v = cp - 32'h10000;
      dec_unit(32'hD800 | ((v >> 10) & 32'h3FF), ERR_OK);
      dec_unit(32'hDC00 | (v & 32'h3FF), ERR_OK);
    end else begin
      dec_unit(cp, ERR_OK);
    end
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void dec_clear();
    dec_phase  = PH_IDLE;
    dec_acc    = 32'h0;
    oct_digits = 2'd0;
    cont_left  = 2'd0;
    seq_len    = 3'd0;
  endfunction

  function automatic void dec_lead(input logic [31:0] bits, input logic [2:0] len);
    dec_acc   = bits;
    seq_len   = len;
    cont_left = 2'(len - 3'd1);
    dec_phase = PH_UTF8;
  endfunction

  function automatic void dec_idle_byte(input logic [7:0] b);
    dec_clear();
    if (b == BSL)                     dec_phase = PH_ESC;
    else if (b < 8'h80)               dec_char({24'h0, b}, 1'b0);
    else if (b >= 8'hC0 && b <= 8'hDF) dec_lead({27'h0, b[4:0]}, 3'd2);
    else if (b >= 8'hE0 && b <= 8'hEF) dec_lead({28'h0, b[3:0]}, 3'd3);
    else if (b >= 8'hF0 && b <= 8'hF7) dec_lead({29'h0, b[2:0]}, 3'd4);
    else                              dec_unit(32'h0, ERR_UTF8);
  endfunction

  function automatic void dec_esc_byte(input logic [7:0] b);
    dec_clear();
    case (b)
      "'", "\"", "?", BSL: dec_char({24'h0, b}, 1'b0);
      // control characters by their code values
      "a": dec_char(32'd7, 1'b0);
      "b": dec_char(32'd8, 1'b0);
      "f": dec_char(32'd12, 1'b0);
      "n": dec_char(32'd10, 1'b0);
      "r": dec_char(32'd13, 1'b0);
      "t": dec_char(32'd9, 1'b0);
      "v": dec_char(32'd11, 1'b0);
      "x": dec_phase = PH_HEXFIRST;
      default: begin
        if (b >= "0" && b <= "7") begin
          dec_acc    = {29'h0, b[2:0]};
          oct_digits = 2'd1;
          dec_phase  = PH_OCT;
        end else begin
          dec_unit(32'h0, ERR_ESCAPE);
        end
      end
    endcase
  endfunction

  function automatic void dec_body(input logic [7:0] b);
    int          h;
    logic [31:0] floor_cp;
    case (dec_phase)
      PH_ESC: dec_esc_byte(b);
      PH_HEXFIRST, PH_HEX, PH_HEXOVF: begin
        h = hex_val(b);
        if (h >= 0) begin
          // Absorb digits once overflowed; flag overflow before the shift
          if (dec_phase == PH_HEX && dec_acc > 32'h0FFFFFFF) begin
            dec_phase = PH_HEXOVF;
          end else if (dec_phase != PH_HEXOVF) begin
            dec_acc   = dec_acc * 16 + 32'(h);
            dec_phase = PH_HEX;
          end
        end else begin
          if (dec_phase == PH_HEXFIRST)     dec_unit(32'h0, ERR_ESCAPE);
          else if (dec_phase == PH_HEXOVF)  dec_unit(32'h0, ERR_RANGE);
          else                              dec_char(dec_acc, 1'b1);
          dec_idle_byte(b);
        end
      end
      PH_OCT: begin
        if (b >= "0" && b <= "7") begin
          dec_acc    = dec_acc * 8 + {29'h0, b[2:0]};
          oct_digits = oct_digits + 2'd1;
          if (oct_digits == 2'd3) begin
            dec_char(dec_acc, 1'b1);
            dec_clear();
          end
        end else begin
          dec_char(dec_acc, 1'b1);
          dec_idle_byte(b);
        end
      end
      PH_UTF8: begin
        if (b[7:6] != 2'b10) begin
          dec_unit(32'h0, ERR_UTF8);
          dec_idle_byte(b);
        end else begin
          dec_acc = ((dec_acc << 6) | {26'h0, b[5:0]}) & 32'h1FFFFF;
          if (cont_left > 2'd1) begin
            cont_left = cont_left - 2'd1;
          end else begin
            floor_cp = (seq_len == 3'd2) ? 32'h80 : (seq_len == 3'd3) ? 32'h800 : 32'h10000;
            if (dec_acc < floor_cp || (dec_acc >= 32'hD800 && dec_acc <= 32'hDFFF) ||
                dec_acc > 32'h10FFFF)
              dec_unit(32'h0, ERR_UTF8);
            else
              dec_char(dec_acc, 1'b0);
            dec_clear();
          end
        end
      end
      default: dec_idle_byte(b);
    endcase
  endfunction

  // Close whatever is open, then append the terminating zero unit
  function automatic void dec_end();
    case (dec_phase)
      PH_HEX, PH_OCT:       dec_char(dec_acc, 1'b1);
      PH_HEXOVF:            dec_unit(32'h0, ERR_RANGE);
      PH_ESC, PH_HEXFIRST:  dec_unit(32'h0, ERR_ESCAPE);
      PH_UTF8:              dec_unit(32'h0, ERR_UTF8);
      default: ;
    endcase
    dec_clear();
    dec_char(32'h0, 1'b0);
  endfunction

  // ---------------------------------------------------------------- drivers

  // Present one input transaction after a random gap; book its units on acceptance
  task automatic send_item(input logic act, input logic [7:0] b, input logic known,
                           input logic [31:0] k_unit, input logic [ERR_W-1:0] k_err);
    int gap;
    if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_taken++;
    step_n = 0;
    if (act == ACT_END) dec_end();
    else                dec_body(b);
    if (known) begin
      units_due.push_back(unit_rec_t'{k_unit, k_err, 1'b1});
    end else begin
      for (int i = 0; i < step_n; i++)
        units_due.push_back(unit_rec_t'{step_unit[i], step_err[i], i == step_n - 1});
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ACT_BYTE, b, PREDICTED, 32'h0, ERR_OK);
  endtask

  // The byte rides along with the end action but must be ignored
  task automatic send_end();
    send_item(ACT_END, 8'($urandom_range(0, 255)), PREDICTED, 32'h0, ERR_OK);
  endtask

  function automatic logic [7:0] hex_char(input int k);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("a" + k - 10);
    return 8'("A" + k - 16);
  endfunction

  // Send the first keep bytes of the len-byte UTF-8 form of cp, legal or not
  task automatic send_utf8(input logic [31:0] cp, input int len, input int keep);
    logic [7:0] b;
    for (int i = 0; i < keep; i++) begin
      if (i == 0) begin
        if (len == 2)      b = 8'hC0 | 8'((cp >> 6) & 32'h1F);
        else if (len == 3) b = 8'hE0 | 8'((cp >> 12) & 32'h0F);
        else               b = 8'hF0 | 8'((cp >> 18) & 32'h07);
      end else begin
        b = 8'h80 | 8'((cp >> (6 * (len - 1 - i))) & 32'h3F);
      end
      send_byte(b);
    end
  endtask

  // Mostly well-formed constructs with random content, the rest noise and breakage
  task automatic send_token();
    int          pick;
    int          n;
    int          len;
    logic [31:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_byte(8'($urandom_range(0, 127)));
    end else if (pick < 36) begin
      send_byte(BSL);
      send_byte(simple_letters[$urandom_range(0, 10)]);
    end else if (pick < 48) begin
      send_byte(BSL);
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'("0" + $urandom_range(0, 7)));
    end else if (pick < 60) begin
      // occasionally long enough to overflow 32 bits
      send_byte(BSL);
      send_byte("x");
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 4);
      repeat (n) send_byte(hex_char($urandom_range(0, 21)));
    end else if (pick < 78) begin
      len = $urandom_range(2, 4);
      if (len == 2) begin
        cp = $urandom_range(32'h80, 32'h7FF);
      end else if (len == 3) begin
        cp = $urandom_range(32'h800, 32'hFFFF);
        if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp - 32'h1000;
      end else begin
        cp = $urandom_range(32'h10000, 32'h10FFFF);
      end
      send_utf8(cp, len, len);
    end else if (pick < 85) begin
      // overlong, surrogate or beyond the Unicode range
      case ($urandom_range(0, 4))
        0: send_utf8($urandom_range(0, 32'h7F), 2, 2);
        1: send_utf8($urandom_range(0, 32'h7FF), 3, 3);
        2: send_utf8($urandom_range(32'hD800, 32'hDFFF), 3, 3);
        3: send_utf8($urandom_range(0, 32'hFFFF), 4, 4);
        default: send_utf8($urandom_range(32'h110000, 32'h1FFFFF), 4, 4);
      endcase
    end else if (pick < 93) begin
      // cut a construct short, then end the literal or hit it with any byte
      case ($urandom_range(0, 3))
        0: begin
          len = $urandom_range(2, 4);
          send_utf8($urandom_range(32'h10000, 32'h10FFFF), len, $urandom_range(1, len - 1));
        end
        1: send_byte(BSL);
        2: begin
          send_byte(BSL);
          send_byte("x");
        end
        default: begin
          send_byte(BSL);
          send_byte(8'($urandom_range(0, 255)));
        end
      endcase
      if ($urandom_range(0, 1) == 0) send_end();
      else                           send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_end();
    end
  endtask

  // Change the unit width only once the block has drained
  task automatic set_mode(input logic [MODE_W-1:0] m);
    @(negedge clk) in_tvalid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    unit_mode = m;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  // Stall the result channel for a random gap before each transaction
  initial begin : result_ready
    int gap;
    out_tready = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      gap = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each result transaction with the oldest unit owed
  always @(posedge clk) begin : check_units
    unit_rec_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (units_due.size() == 0) begin
        $display("%0t: unit with none due: expected none, got unit %h error %0d last %0b",
                 $time, out_tdata[UNIT_W-1:0], out_tdata[UNIT_W +: ERR_W], out_tlast);
        mismatches++;
      end else begin
        due = units_due.pop_front();
        if (out_tdata[UNIT_W-1:0] !== due.unit) begin
          $display("%0t: code unit expected %h got %h", $time, due.unit,
                   out_tdata[UNIT_W-1:0]);
          mismatches++;
        end
        if (out_tdata[UNIT_W +: ERR_W] !== due.err) begin
          $display("%0t: error code expected %0d got %0d", $time, due.err,
                   out_tdata[UNIT_W +: ERR_W]);
          mismatches++;
        end
        if (out_tlast !== due.last) begin
          $display("%0t: last expected %0b got %0b", $time, due.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int base;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = ACT_BYTE;
    in_tdata  = 8'h00;
    cfg_valid = 1'b0;
    cfg_data  = MODE_8;
    unit_mode = MODE_8;
    dec_clear();
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int i = 0; i < INTRO_N; i++)
      send_item(intro_rows[i].act, intro_rows[i].data, intro_rows[i].known,
                intro_rows[i].unit, intro_rows[i].err);

    // One random phase per width code; close each literal so the decoder idles
    for (int p = 0; p < 4; p++) begin
      set_mode(phase_modes[p]);
      base = items_taken;
      while (items_taken - base < PHASE_ITEMS) send_token();
      send_end();
    end

    @(negedge clk) in_tvalid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && units_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
